[design/lcdseq_pkg.sv]
package lcdseq_pkg;

    // Command codes on the input func field
    localparam logic [2:0] FUNC_RAW    = 3'd0;
    localparam logic [2:0] FUNC_CHAR   = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_VALUE  = 3'd4;
    localparam logic [2:0] FUNC_INIT   = 3'd5;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  CFG_BIT_HOLD    = 2'd0;
    localparam logic [1:0]  CFG_CHAR_HOLD   = 2'd1;
    localparam logic [1:0]  CFG_INSTR_HOLD  = 2'd2;

    localparam logic [15:0] BIT_HOLD_RST    = 16'd2;
    localparam logic [15:0] CHAR_HOLD_RST   = 16'd200;
    localparam logic [15:0] INSTR_HOLD_RST  = 16'd1000;

    // Line base addresses and the ASCII digit high nibble
    localparam logic [7:0]  LINE0_BASE      = 8'h80;
    localparam logic [7:0]  LINE1_BASE      = 8'hC0;
    localparam logic [3:0]  ASCII_DIGIT_HI  = 4'h3;

    // Microprogram address width and entry points
    localparam int          UADDR_W         = 4;
    localparam logic [3:0]  UA_RAW          = 4'd0;
    localparam logic [3:0]  UA_CHAR         = 4'd1;
    localparam logic [3:0]  UA_CLEAR        = 4'd2;
    localparam logic [3:0]  UA_CURSOR       = 4'd4;
    localparam logic [3:0]  UA_VALUE        = 4'd5;
    localparam logic [3:0]  UA_INIT         = 4'd8;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_DATA,
        SRC_CURSOR,
        SRC_HUND,
        SRC_TENS,
        SRC_UNITS
    } src_t;

    typedef enum logic [1:0] {
        REST_ZERO,
        REST_CHAR,
        REST_INSTR
    } rest_t;

    typedef enum logic [2:0] {
        PH_HI_EN,
        PH_HI,
        PH_LO_EN,
        PH_LO,
        PH_REST
    } phase_t;

    // One control word: one byte sent to the display
    typedef struct packed {
        src_t                 src;
        logic [7:0]           const_byte;
        logic                 rs;
        rest_t                rest;
        logic                 wait_digits;
        logic                 last;
        logic                 jump;
        logic [UADDR_W-1:0]   target;
    } ucw_t;

    // Digit converter handshake
    typedef struct packed {
        logic       done;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // Entry address of each command's microroutine
    function automatic logic [UADDR_W-1:0] entry_addr(input logic [2:0] func);
        logic [UADDR_W-1:0] a;
        a = UA_RAW;
        case (func)
            FUNC_RAW:    a = UA_RAW;
            FUNC_CHAR:   a = UA_CHAR;
            FUNC_CLEAR:  a = UA_CLEAR;
            FUNC_CURSOR: a = UA_CURSOR;
            FUNC_VALUE:  a = UA_VALUE;
            FUNC_INIT:   a = UA_INIT;
            default:     a = UA_RAW;
        endcase
        return a;
    endfunction

endpackage

[design/lcdseq_urom.sv]
module lcdseq_urom (
    input  logic [lcdseq_pkg::UADDR_W-1:0] addr,
    output lcdseq_pkg::ucw_t               ucw
);
    import lcdseq_pkg::*;

    function automatic ucw_t mk(input src_t src, input logic [7:0] cb, input logic rs,
                                input rest_t rest, input logic wd, input logic last,
                                input logic jump, input logic [UADDR_W-1:0] tgt);
        ucw_t w;
        w.src         = src;
        w.const_byte  = cb;
        w.rs          = rs;
        w.rest        = rest;
        w.wait_digits = wd;
        w.last        = last;
        w.jump        = jump;
        w.target      = tgt;
        return w;
    endfunction

    // Microprogram: one word per byte, init falls into the clear routine
    always_comb begin
        case (addr)
            4'd0:    ucw = mk(SRC_DATA,   8'h00, 1'b0, REST_ZERO,  1'b0, 1'b1, 1'b0, UA_RAW);
            4'd1:    ucw = mk(SRC_DATA,   8'h00, 1'b1, REST_CHAR,  1'b0, 1'b1, 1'b0, UA_RAW);
            4'd2:    ucw = mk(SRC_CONST,  8'h01, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b0, UA_RAW);
            4'd3:    ucw = mk(SRC_CONST,  8'h02, 1'b0, REST_INSTR, 1'b0, 1'b1, 1'b0, UA_RAW);
            4'd4:    ucw = mk(SRC_CURSOR, 8'h00, 1'b0, REST_ZERO,  1'b0, 1'b1, 1'b0, UA_RAW);
            4'd5:    ucw = mk(SRC_HUND,   8'h00, 1'b1, REST_CHAR,  1'b1, 1'b0, 1'b0, UA_RAW);
            4'd6:    ucw = mk(SRC_TENS,   8'h00, 1'b1, REST_CHAR,  1'b1, 1'b0, 1'b0, UA_RAW);
            4'd7:    ucw = mk(SRC_UNITS,  8'h00, 1'b1, REST_CHAR,  1'b1, 1'b1, 1'b0, UA_RAW);
            4'd8:    ucw = mk(SRC_CONST,  8'h33, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b0, UA_RAW);
            4'd9:    ucw = mk(SRC_CONST,  8'h32, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b0, UA_RAW);
            4'd10:   ucw = mk(SRC_CONST,  8'h2C, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b0, UA_RAW);
            4'd11:   ucw = mk(SRC_CONST,  8'h06, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b0, UA_RAW);
            4'd12:   ucw = mk(SRC_CONST,  8'h0C, 1'b0, REST_INSTR, 1'b0, 1'b0, 1'b1, UA_CLEAR);
            default: ucw = mk(SRC_CONST,  8'h00, 1'b0, REST_ZERO,  1'b0, 1'b1, 1'b0, UA_RAW);
        endcase
    end

endmodule

[design/lcdseq_bcd.sv]
module lcdseq_bcd (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [15:0]         value,
    output lcdseq_pkg::digits_t digits
);
    import lcdseq_pkg::*;

    logic [15:0] bin_reg,  bin_next;
    logic [11:0] bcd_reg,  bcd_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        done_reg, done_next;
    logic [11:0] adj;

    // Add three to each digit of five or more, then shift in one bit
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ?
                            bcd_reg[d*4 +: 4] + 4'd3 : bcd_reg[d*4 +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start) begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            done_next = 1'b0;
        end else if (!done_reg) begin
            bcd_next  = {adj[10:0], bin_reg[15]};
            bin_next  = {bin_reg[14:0], 1'b0};
            cnt_next  = cnt_reg + 5'd1;
            done_next = (cnt_reg == 5'd15);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b1;
            cnt_reg  <= '0;
        end else begin
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign digits.done  = done_reg;
    assign digits.hund  = bcd_reg[11:8];
    assign digits.tens  = bcd_reg[7:4];
    assign digits.units = bcd_reg[3:0];

endmodule

[design/char_lcd_nibble_write_sequencer.sv]
// Character LCD 4-bit write sequencer.
// Input channel (s_*): one command per request. Func 0..5 selects raw
// instruction, data character, clear and home, cursor move, three-digit
// value display or the power-up initialise sequence; func 6 and 7 are
// accepted and produce nothing.
// Output channel (m_*): one request per bus phase. Each byte becomes five
// phases (high nibble E high / E low, low nibble E high / E low, rest
// phase with RS set). m_last marks the final phase of a command.
// Configuration: cfg_wr_en writes cfg_data into bit_hold (0), char_hold
// (1) or instr_hold (2); other indexes are ignored. Write only when idle.
// Timing: the microcode step counter issues one phase per cycle into the
// output register while neither m_ready nor the BCD converter holds it;
// a command has 5 to 35 phases. Value display first waits for the serial
// BCD converter, which starts when the command is taken. s_ready returns
// high in the cycle after the final phase is loaded, so the next command
// overlaps delivery of that phase.
// A stalled m_ready holds the current phase and freezes the sequencer.
// Reset clears the sequencer and output valid and loads the hold
// registers with 2, 200 and 1000.
module char_lcd_nibble_write_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_data_byte,
    input  logic        s_row,
    input  logic [5:0]  s_column,
    input  logic [15:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_bus_nibble,
    output logic        m_reg_select,
    output logic        m_enable,
    output logic [15:0] m_hold_ticks,
    output logic        m_last,
    input  logic        cfg_wr_en,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import lcdseq_pkg::*;

    logic [15:0]        bit_hold_reg,   bit_hold_next;
    logic [15:0]        char_hold_reg,  char_hold_next;
    logic [15:0]        instr_hold_reg, instr_hold_next;

    logic               busy_reg,  busy_next;
    logic [UADDR_W-1:0] upc_reg,   upc_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         data_reg,  data_next;
    logic [7:0]         cursor_reg, cursor_next;

    logic               mv_reg,    mv_next;
    logic [3:0]         nib_reg,   nib_next;
    logic               rs_reg,    rs_next;
    logic               en_reg,    en_next;
    logic [15:0]        hold_reg,  hold_next;
    logic               last_reg,  last_next;

    logic               accept;
    logic               func_ok;
    logic               out_free;
    logic               step;
    ucw_t               ucw;
    digits_t            digits;
    logic [7:0]         cur_byte;
    logic [15:0]        rest_hold;

    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign func_ok  = (s_func inside {[FUNC_RAW:FUNC_INIT]});
    assign out_free = !mv_reg || m_ready;
    assign step     = busy_reg && out_free && (!ucw.wait_digits || digits.done);

    lcdseq_urom u_urom (
        .addr (upc_reg),
        .ucw  (ucw)
    );

    lcdseq_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .value   (s_value),
        .digits  (digits)
    );

    // Configuration writes
    always_comb begin
        bit_hold_next   = bit_hold_reg;
        char_hold_next  = char_hold_reg;
        instr_hold_next = instr_hold_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BIT_HOLD:   bit_hold_next   = cfg_data;
                CFG_CHAR_HOLD:  char_hold_next  = cfg_data;
                CFG_INSTR_HOLD: instr_hold_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Select the byte for the current control word
    always_comb begin
        case (ucw.src)
            SRC_CONST:  cur_byte = ucw.const_byte;
            SRC_DATA:   cur_byte = data_reg;
            SRC_CURSOR: cur_byte = cursor_reg;
            SRC_HUND:   cur_byte = {ASCII_DIGIT_HI, digits.hund};
            SRC_TENS:   cur_byte = {ASCII_DIGIT_HI, digits.tens};
            SRC_UNITS:  cur_byte = {ASCII_DIGIT_HI, digits.units};
            default:    cur_byte = ucw.const_byte;
        endcase
    end

    always_comb begin
        case (ucw.rest)
            REST_ZERO:  rest_hold = '0;
            REST_CHAR:  rest_hold = char_hold_reg;
            REST_INSTR: rest_hold = instr_hold_reg;
            default:    rest_hold = '0;
        endcase
    end

    // Sequencer: take a command, then advance phase and step counter
    always_comb begin
        busy_next   = busy_reg;
        upc_next    = upc_reg;
        phase_next  = phase_reg;
        data_next   = data_reg;
        cursor_next = cursor_reg;
        if (accept) begin
            busy_next   = func_ok;
            upc_next    = entry_addr(s_func);
            phase_next  = PH_HI_EN;
            data_next   = s_data_byte;
            cursor_next = (s_row ? LINE1_BASE : LINE0_BASE) + {2'b00, s_column};
        end else if (step) begin
            if (phase_reg == PH_REST) begin
                phase_next = PH_HI_EN;
                if (ucw.last) begin
                    busy_next = 1'b0;
                end else if (ucw.jump) begin
                    upc_next = ucw.target;
                end else begin
                    upc_next = upc_reg + UADDR_W'(1);
                end
            end else begin
                phase_next = phase_t'(phase_reg + 3'd1);
            end
        end
    end

    // Output register: load a phase, drop valid once taken
    always_comb begin
        mv_next   = mv_reg && !m_ready;
        nib_next  = nib_reg;
        rs_next   = rs_reg;
        en_next   = en_reg;
        hold_next = hold_reg;
        last_next = last_reg;
        if (step) begin
            mv_next   = 1'b1;
            rs_next   = ucw.rs;
            hold_next = bit_hold_reg;
            last_next = 1'b0;
            case (phase_reg)
                PH_HI_EN: begin nib_next = cur_byte[7:4]; en_next = 1'b1; end
                PH_HI:    begin nib_next = cur_byte[7:4]; en_next = 1'b0; end
                PH_LO_EN: begin nib_next = cur_byte[3:0]; en_next = 1'b1; end
                PH_LO:    begin nib_next = cur_byte[3:0]; en_next = 1'b0; end
                PH_REST: begin
                    nib_next  = '0;
                    en_next   = 1'b0;
                    rs_next   = 1'b1;
                    hold_next = rest_hold;
                    last_next = ucw.last;
                end
                default: begin nib_next = '0; en_next = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_hold_reg   <= BIT_HOLD_RST;
            char_hold_reg  <= CHAR_HOLD_RST;
            instr_hold_reg <= INSTR_HOLD_RST;
            busy_reg       <= 1'b0;
            upc_reg        <= UA_RAW;
            phase_reg      <= PH_HI_EN;
            mv_reg         <= 1'b0;
        end else begin
            bit_hold_reg   <= bit_hold_next;
            char_hold_reg  <= char_hold_next;
            instr_hold_reg <= instr_hold_next;
            busy_reg       <= busy_next;
            upc_reg        <= upc_next;
            phase_reg      <= phase_next;
            mv_reg         <= mv_next;
        end
        data_reg   <= data_next;
        cursor_reg <= cursor_next;
        nib_reg    <= nib_next;
        rs_reg     <= rs_next;
        en_reg     <= en_next;
        hold_reg   <= hold_next;
        last_reg   <= last_next;
    end

    assign m_valid      = mv_reg;
    assign m_bus_nibble = nib_reg;
    assign m_reg_select = rs_reg;
    assign m_enable     = en_reg;
    assign m_hold_ticks = hold_reg;
    assign m_last       = last_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func_ok |=> busy_reg)
        else $error("valid command did not start the sequencer");

    a_rest_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_REST |=> !m_enable && m_reg_select && m_bus_nibble == 4'h0)
        else $error("rest phase has wrong pin levels");

    a_digits_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        step && ucw.wait_digits |-> digits.done)
        else $error("digit byte sent before conversion finished");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_REST && ucw.last |=> !busy_reg && m_last)
        else $error("final phase did not end the command");
`endif

endmodule

[bench/char_lcd_nibble_write_sequencer_test.sv]
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_test;
    import lcdseq_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int SETTLE_CYCLES     = 64;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int ITEMS_PER_SETTING = 50;
    localparam int MAX_REPORTS       = 10;
    localparam int DIRECTED_COUNT    = 20;

    // Func codes with no routine behind them, and the index past the last register
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    localparam logic [7:0] DISP_CLEAR  = 8'h01;
    localparam logic [7:0] DISP_HOME   = 8'h02;
    localparam logic [3:0] REST_NIBBLE = 4'h0;

    // One bus phase as seen on the result channel
    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic        en;
        logic [15:0] hold;
        logic        fin;
    } bus_phase_t;

    // One command request; typed rows carry their own expected byte
    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data;
        logic        line;
        logic [5:0]  col;
        logic [15:0] val;
        logic        typed;
        logic        has_byte;
        logic [7:0]  t_byte;
        logic        t_rs;
        logic [15:0] t_rest;
    } cmd_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    cmd_row_t    cur_cmd;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_bus_nibble;
    logic        m_reg_select;
    logic        m_enable;
    logic [15:0] m_hold_ticks;
    logic        m_last;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the hold registers
    logic [15:0] strobe_hold;
    logic [15:0] char_wait;
    logic [15:0] instr_wait;

    bus_phase_t  pending_phases[$];
    int          cycle_count = 0;
    int          phases_checked = 0;
    int          mismatches = 0;
    int          cmds_by_func[0:7];
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;
    int          stall;

    // Reset values apply to the typed rows
    cmd_row_t directed_cmds[0:DIRECTED_COUNT-1] = '{
        '{FUNC_RAW,    8'h00, 1'b1, 6'd63, 16'hFFFF, 1'b1, 1'b1, 8'h00, 1'b0, 16'd0},
        '{FUNC_RAW,    8'hFF, 1'b0, 6'd0,  16'h0000, 1'b1, 1'b1, 8'hFF, 1'b0, 16'd0},
        '{FUNC_CHAR,   8'h00, 1'b1, 6'd42, 16'hA5A5, 1'b1, 1'b1, 8'h00, 1'b1, CHAR_HOLD_RST},
        '{FUNC_CHAR,   8'hFF, 1'b0, 6'd21, 16'h5A5A, 1'b1, 1'b1, 8'hFF, 1'b1, CHAR_HOLD_RST},
        '{FUNC_CLEAR,  8'h81, 1'b1, 6'd5,  16'd12,   1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_CURSOR, 8'hFF, 1'b0, 6'd0,  16'd0,    1'b1, 1'b1, 8'h80, 1'b0, 16'd0},
        '{FUNC_CURSOR, 8'h00, 1'b1, 6'd63, 16'd0,    1'b1, 1'b1, 8'hFF, 1'b0, 16'd0},
        '{FUNC_CURSOR, 8'h00, 1'b0, 6'd63, 16'd0,    1'b1, 1'b1, 8'hBF, 1'b0, 16'd0},
        '{FUNC_CURSOR, 8'h00, 1'b1, 6'd0,  16'd0,    1'b1, 1'b1, 8'hC0, 1'b0, 16'd0},
        '{FUNC_VALUE,  8'h00, 1'b0, 6'd0,  16'd0,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_VALUE,  8'h00, 1'b0, 6'd0,  16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_VALUE,  8'h00, 1'b0, 6'd0,  16'd999,  1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_VALUE,  8'h00, 1'b0, 6'd0,  16'd1000, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_VALUE,  8'h00, 1'b0, 6'd0,  16'd7,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_INIT,   8'h55, 1'b1, 6'd9,  16'd300,  1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_SPARE6, 8'hFF, 1'b1, 6'd63, 16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_RAW,    8'h3C, 1'b0, 6'd0,  16'd0,    1'b1, 1'b1, 8'h3C, 1'b0, 16'd0},
        '{FUNC_SPARE7, 8'h00, 1'b0, 6'd0,  16'd0,    1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_CHAR,   8'h5A, 1'b0, 6'd0,  16'd0,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
        '{FUNC_CURSOR, 8'h00, 1'b1, 6'd21, 16'd0,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0}
    };

    char_lcd_nibble_write_sequencer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (cur_cmd.func),
        .s_data_byte  (cur_cmd.data),
        .s_row        (cur_cmd.line),
        .s_column     (cur_cmd.col),
        .s_value      (cur_cmd.val),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bus_nibble (m_bus_nibble),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_hold_ticks (m_hold_ticks),
        .m_last       (m_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Power-up byte order: wake-up, 4-bit switch, function set, entry mode, display on
    function automatic logic [7:0] init_byte(input int n);
        case (n)
            0:       return 8'h33;
            1:       return 8'h32;
            2:       return 8'h2C;
            3:       return 8'h06;
            default: return 8'h0C;
        endcase
    endfunction

    // Queue the five phases of one byte; the rest phase always shows RS high
    function automatic void push_byte(input logic [7:0] b, input logic rs,
                                      input logic [15:0] rest, input logic fin);
        pending_phases.push_back({b[7:4], rs, 1'b1, strobe_hold, 1'b0});
        pending_phases.push_back({b[7:4], rs, 1'b0, strobe_hold, 1'b0});
        pending_phases.push_back({b[3:0], rs, 1'b1, strobe_hold, 1'b0});
        pending_phases.push_back({b[3:0], rs, 1'b0, strobe_hold, 1'b0});
        pending_phases.push_back({REST_NIBBLE, 1'b1, 1'b0, rest, fin});
    endfunction

    // Expand one command into its bus phases
    function automatic void expand_command(input cmd_row_t c);
        logic [7:0]  addr;
        logic [15:0] hund;
        logic [15:0] tens;
        logic [15:0] units;
        int          i;
        case (c.func)
            FUNC_RAW: begin
                push_byte(c.data, 1'b0, 16'd0, 1'b1);
            end
            FUNC_CHAR: begin
                push_byte(c.data, 1'b1, char_wait, 1'b1);
            end
            FUNC_CLEAR: begin
                push_byte(DISP_CLEAR, 1'b0, instr_wait, 1'b0);
                push_byte(DISP_HOME, 1'b0, instr_wait, 1'b1);
            end
            FUNC_CURSOR: begin
                addr = (c.line ? LINE1_BASE : LINE0_BASE) + {2'b00, c.col};
                push_byte(addr, 1'b0, 16'd0, 1'b1);
            end
            FUNC_VALUE: begin
                // thousands and above are dropped
                hund  = (c.val / 16'd100) % 16'd10;
                tens  = (c.val / 16'd10) % 16'd10;
                units = c.val % 16'd10;
                push_byte({ASCII_DIGIT_HI, hund[3:0]}, 1'b1, char_wait, 1'b0);
                push_byte({ASCII_DIGIT_HI, tens[3:0]}, 1'b1, char_wait, 1'b0);
                push_byte({ASCII_DIGIT_HI, units[3:0]}, 1'b1, char_wait, 1'b1);
            end
            FUNC_INIT: begin
                for (i = 0; i < 5; i++) begin
                    push_byte(init_byte(i), 1'b0, instr_wait, 1'b0);
                end
                push_byte(DISP_CLEAR, 1'b0, instr_wait, 1'b0);
                push_byte(DISP_HOME, 1'b0, instr_wait, 1'b1);
            end
            default: begin
                // spare codes emit nothing
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function automatic cmd_row_t random_command();
        cmd_row_t    c;
        logic [31:0] r;
        logic [31:0] v;
        int          pick;
        c = '0;
        pick = $urandom_range(0, 99);
        if (pick < 18)      c.func = FUNC_RAW;
        else if (pick < 36) c.func = FUNC_CHAR;
        else if (pick < 48) c.func = FUNC_CLEAR;
        else if (pick < 66) c.func = FUNC_CURSOR;
        else if (pick < 84) c.func = FUNC_VALUE;
        else if (pick < 94) c.func = FUNC_INIT;
        else if (pick < 97) c.func = FUNC_SPARE6;
        else                c.func = FUNC_SPARE7;
        r = $urandom();
        c.data = r[7:0];
        c.line = r[8];
        c.col  = r[14:9];
        v = (r[16:15] == 2'b00) ? $urandom_range(0, 999) : $urandom();
        c.val = v[15:0];
        return c;
    endfunction

    // Offer one request and hold it until taken
    task automatic offer_command(input cmd_row_t c);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_cmd = c;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Drop valid, drain all phases, then give a spare command time to finish
    task automatic settle();
        s_valid = 1'b0;
        while (pending_phases.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One hold setting followed by a run of random commands
    task automatic run_setting(input logic [15:0] bh, input logic [15:0] ch,
                               input logic [15:0] ih, input bit squeeze);
        cmd_row_t    c;
        int          issued;
        logic [31:0] r;
        settle();
        write_reg(CFG_BIT_HOLD, bh);
        write_reg(CFG_CHAR_HOLD, ch);
        write_reg(CFG_INSTR_HOLD, ih);
        if (squeeze) begin
            r = $urandom();
            write_reg(CFG_UNUSED, r[15:0]);
            long_hold = 1'b1;
        end
        issued = 0;
        while (issued < ITEMS_PER_SETTING) begin
            c = random_command();
            offer_command(c);
            issued++;
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    always begin
        @(negedge aclk);
        if (long_hold) begin
            m_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            long_hold = 1'b0;
        end else begin
            stall = quiet ? 0 : pick_gap();
            m_ready = (stall == 0);
            if (stall > 1) repeat (stall - 1) @(negedge aclk);
        end
    end

    // Track registers, predict on each taken command, check each taken phase
    always @(posedge aclk) begin
        bus_phase_t got;
        bus_phase_t want;
        cycle_count++;
        if (!aresetn) begin
            strobe_hold = BIT_HOLD_RST;
            char_wait   = CHAR_HOLD_RST;
            instr_wait  = INSTR_HOLD_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BIT_HOLD:   strobe_hold = cfg_data;
                    CFG_CHAR_HOLD:  char_wait = cfg_data;
                    CFG_INSTR_HOLD: instr_wait = cfg_data;
                    default:        ;
                endcase
            end
            if (s_valid && s_ready) begin
                cmds_by_func[cur_cmd.func]++;
                if (!cur_cmd.typed) begin
                    expand_command(cur_cmd);
                end else if (cur_cmd.has_byte) begin
                    push_byte(cur_cmd.t_byte, cur_cmd.t_rs, cur_cmd.t_rest, 1'b1);
                end
            end
            if (m_valid && m_ready) begin
                got = {m_bus_nibble, m_reg_select, m_enable, m_hold_ticks, m_last};
                phases_checked++;
                if (pending_phases.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("Unexpected phase %0d: nibble %h rs %b e %b hold %0d last %b",
                                 phases_checked, got.nibble, got.rs, got.en, got.hold,
                                 got.fin);
                    mismatches++;
                end else begin
                    want = pending_phases.pop_front();
                    if (got !== want) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"Phase %0d mismatch (expected/actual): nibble %h/%h ",
                                      "rs %b/%b e %b/%b hold %0d/%0d last %b/%b"},
                                     phases_checked, want.nibble, got.nibble, want.rs, got.rs,
                                     want.en, got.en, want.hold, got.hold, want.fin, got.fin);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles with %0d phases pending",
                 cycle_count, pending_phases.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [31:0] r1;
        logic [31:0] r2;
        foreach (cmds_by_func[i]) cmds_by_func[i] = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        cur_cmd   = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_BIT_HOLD;
        cfg_data  = 16'd0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table at reset hold values
        foreach (directed_cmds[i]) offer_command(directed_cmds[i]);

        // Random runs over several hold settings
        run_setting(16'd0, 16'd0, 16'd0, 1'b0);
        quiet = 1'b1;
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        quiet = 1'b0;
        r1 = $urandom();
        r2 = $urandom();
        run_setting(r1[15:0], r1[31:16], r2[15:0], 1'b1);
        run_setting(16'd1, 16'h8000, 16'h7FFF, 1'b0);
        r1 = $urandom();
        r2 = $urandom();
        run_setting({8'h00, r1[7:0]}, r1[31:16], r2[31:16], 1'b0);
        settle();

        mismatches += pending_phases.size();
        $display("Checked %0d bus phases from %0d directed and random commands",
                 phases_checked, cmds_by_func.sum());
        $display({"Mix: raw %0d, char %0d, clear %0d, cursor %0d, value %0d, init %0d, ",
                  "spare %0d; six hold settings, one long output stall"},
                 cmds_by_func[0], cmds_by_func[1], cmds_by_func[2], cmds_by_func[3],
                 cmds_by_func[4], cmds_by_func[5], cmds_by_func[6] + cmds_by_func[7]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
design/lcdseq_pkg.sv
design/lcdseq_urom.sv
design/lcdseq_bcd.sv
design/char_lcd_nibble_write_sequencer.sv
bench/char_lcd_nibble_write_sequencer_test.sv
